@@ src/tps_pkg.sv @@
// shared types and constants of the tone prescaler period search
package tps_pkg;

  localparam int unsigned FREQ_W   = 24;
  localparam int unsigned PRESC_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MATCH_W  = 15;
  localparam int unsigned HZ_W     = 32;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ  = 2'd0,
    REG_PERIOD_LO = 2'd1,
    REG_PERIOD_HI = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  localparam logic [HZ_W-1:0]     CLOCK_HZ_RST  = 32'd80000000;
  localparam logic [PERIOD_W-1:0] PERIOD_LO_RST = 16'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_HI_RST = 16'd65535;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'hFFFF;
  localparam logic [DIV_W-1:0]    ERR_INIT      = 32'hFFFFFFFF;

  // divider handshake
  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/tps_ifs.sv @@
// request and result channel interfaces of the tone prescaler period search
interface tps_in_if;
  import tps_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  modport source (output valid, output frequency, input ready);
  modport sink   (input valid, input frequency, output ready);
endinterface

interface tps_out_if;
  import tps_pkg::*;
  logic                valid;
  logic                ready;
  logic [PRESC_W-1:0]  prescaler;
  logic [PERIOD_W-1:0] period;
  logic [MATCH_W-1:0]  match;
  logic [HZ_W-1:0]     achieved_hz;
  logic                clamped;
  logic                silent;
  modport source (output valid, output prescaler, output period, output match,
                  output achieved_hz, output clamped, output silent, input ready);
  modport sink   (input valid, input prescaler, input period, input match,
                  input achieved_hz, input clamped, input silent, output ready);
endinterface

@@ src/tone_prescaler_period_search_unit.sv @@
// top level of the tone prescaler period search
// Takes a tone frequency word and returns one word of timer settings. All
// divisions run on one shared 32-bit restoring divider. A zero frequency
// costs no division; a frequency whose direct period already fits costs 4
// divisions; otherwise the search spends two or three divisions on each
// prescaler tried (up to PRESCALER_STEPS, stopping early on an exact match)
// after the first check, plus two or three final divisions. One word is in
// flight at a time; the input is ready again once the result has moved into
// the output register, which may still wait on the sink meanwhile.
module tone_prescaler_period_search_unit #(
  parameter int unsigned PRESCALER_STEPS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tps_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] wr_data,
  tps_in_if.sink                        req,
  tps_out_if.source                     rsp
);
  import tps_pkg::*;

  localparam int unsigned CNT_W = $clog2(PRESCALER_STEPS + 1);
  localparam logic [CNT_W-1:0] P_LAST = CNT_W'(PRESCALER_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LP_START, S_LP_PCLK, S_LP_PER, S_LP_ACT, S_LP_NEXT,
    S_FN_START, S_FN_PCLK, S_FN_PER, S_FN_ACT, S_DONE
  } state_t;

  state_t state;

  logic [HZ_W-1:0]     clock_hz;
  logic [PERIOD_W-1:0] period_lo;
  logic [PERIOD_W-1:0] period_hi;

  logic [DIV_W-1:0]   freq;
  logic [DIV_W-1:0]   pclk;
  logic [DIV_W-1:0]   per;
  logic [CNT_W-1:0]   p_cnt;
  logic [PRESC_W-1:0] best_p;
  logic [DIV_W-1:0]   best_err;

  logic [PRESC_W-1:0]  res_prescaler;
  logic [PERIOD_W-1:0] res_period;
  logic [HZ_W-1:0]     res_achieved;
  logic                res_clamped;
  logic                res_silent;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic [DIV_W-1:0] q;
  logic             q_fits;
  logic [DIV_W-1:0] err;
  logic             out_free;

  assign q = div_rsp.quotient;
  assign q_fits = (q != '0) && (q >= DIV_W'(period_lo)) && (q <= DIV_W'(period_hi));
  assign err = (q > freq) ? (q - freq) : (freq - q);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz  <= CLOCK_HZ_RST;
      period_lo <= PERIOD_LO_RST;
      period_hi <= PERIOD_HI_RST;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_CLOCK_HZ:  clock_hz  <= wr_data[HZ_W-1:0];
        REG_PERIOD_LO: period_lo <= wr_data[PERIOD_W-1:0];
        REG_PERIOD_HI: period_hi <= wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_req.go <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      div_req.go <= 1'b0;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            freq          <= DIV_W'(req.frequency);
            res_prescaler <= '0;
            res_period    <= '0;
            res_achieved  <= '0;
            res_clamped   <= 1'b0;
            res_silent    <= 1'b0;
            if (req.frequency == '0) begin
              res_silent <= 1'b1;
              state      <= S_DONE;
            end else begin
              div_req.go       <= 1'b1;
              div_req.dividend <= clock_hz;
              div_req.divisor  <= DIV_W'(req.frequency);
              state            <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (div_rsp.done) begin
            best_p   <= '0;
            best_err <= ERR_INIT;
            p_cnt    <= '0;
            state    <= q_fits ? S_FN_START : S_LP_START;
          end
        end
        S_LP_START: begin
          div_req.go       <= 1'b1;
          div_req.dividend <= clock_hz;
          div_req.divisor  <= DIV_W'(p_cnt) + 1'b1;
          state            <= S_LP_PCLK;
        end
        S_LP_PCLK: begin
          if (div_rsp.done) begin
            pclk             <= q;
            div_req.go       <= 1'b1;
            div_req.dividend <= q;
            div_req.divisor  <= freq;
            state            <= S_LP_PER;
          end
        end
        S_LP_PER: begin
          if (div_rsp.done) begin
            if (q_fits) begin
              div_req.go       <= 1'b1;
              div_req.dividend <= pclk;
              div_req.divisor  <= q;
              state            <= S_LP_ACT;
            end else begin
              state <= S_LP_NEXT;
            end
          end
        end
        S_LP_ACT: begin
          if (div_rsp.done) begin
            if (err < best_err) begin
              best_err <= err;
              best_p   <= PRESC_W'(p_cnt);
            end
            // exact match ends the search
            state <= (err == '0) ? S_FN_START : S_LP_NEXT;
          end
        end
        S_LP_NEXT: begin
          if (p_cnt == P_LAST) begin
            state <= S_FN_START;
          end else begin
            p_cnt <= p_cnt + 1'b1;
            state <= S_LP_START;
          end
        end
        S_FN_START: begin
          div_req.go       <= 1'b1;
          div_req.dividend <= clock_hz;
          div_req.divisor  <= DIV_W'(best_p) + 1'b1;
          state            <= S_FN_PCLK;
        end
        S_FN_PCLK: begin
          if (div_rsp.done) begin
            pclk             <= q;
            div_req.go       <= 1'b1;
            div_req.dividend <= q;
            div_req.divisor  <= freq;
            state            <= S_FN_PER;
          end
        end
        S_FN_PER: begin
          if (div_rsp.done) begin
            if (q == '0) begin
              res_silent <= 1'b1;
              state      <= S_DONE;
            end else begin
              per              <= q;
              div_req.go       <= 1'b1;
              div_req.dividend <= pclk;
              div_req.divisor  <= q;
              state            <= S_FN_ACT;
            end
          end
        end
        S_FN_ACT: begin
          if (div_rsp.done) begin
            res_prescaler <= best_p;
            res_achieved  <= q;
            res_clamped   <= (per > DIV_W'(PERIOD_MAX));
            res_period    <= (per > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX : per[PERIOD_W-1:0];
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.prescaler   <= res_prescaler;
            rsp.period      <= res_period;
            rsp.match       <= res_period[PERIOD_W-1:1];
            rsp.achieved_hz <= res_achieved;
            rsp.clamped     <= res_clamped;
            rsp.silent      <= res_silent;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/tps_div.sv @@
// shared restoring divider, one quotient bit per cycle
module tps_div (
  input  logic                clk,
  input  logic                rst,
  input  tps_pkg::div_req_t   req,
  output tps_pkg::div_rsp_t   rsp
);
  import tps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] diff;

  assign rem_sh = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (!diff[DIV_W]) begin
          rem <= diff;
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ dv/tone_prescaler_period_search_unit_tb.sv @@
// testbench for the tone prescaler period search: random and directed tones checked per word
module tone_prescaler_period_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam int unsigned SEARCH_STEPS = 256;
  localparam int unsigned FREQ_TOP     = (1 << FREQ_W) - 1;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned GAP_MAX      = 14;

  typedef struct packed {
    logic [PRESC_W-1:0]  prescaler;
    logic [PERIOD_W-1:0] period;
    logic [MATCH_W-1:0]  match;
    logic [HZ_W-1:0]     achieved_hz;
    logic                clamped;
    logic                silent;
  } tone_setting_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  tps_in_if  req_if ();
  tps_out_if rsp_if ();

  tone_prescaler_period_search_unit #(
    .PRESCALER_STEPS(SEARCH_STEPS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // shadow of the timer registers
  logic [HZ_W-1:0]     cfg_clock_hz  = CLOCK_HZ_RST;
  logic [PERIOD_W-1:0] cfg_period_lo = PERIOD_LO_RST;
  logic [PERIOD_W-1:0] cfg_period_hi = PERIOD_HI_RST;

  logic [FREQ_W-1:0] tone_requests[$];
  tone_setting_t     pending_settings[$];
  int unsigned       mismatch_count = 0;
  bit                src_idle_on = 1'b1;
  bit                snk_idle_on = 1'b1;
  bit                hold_request = 1'b0;
  logic              hold_off = 1'b0;
  int unsigned       in_gap;
  int unsigned       out_gap;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit period_fits(longint unsigned per);
    return per != 0 && per >= cfg_period_lo && per <= cfg_period_hi;
  endfunction

  function automatic tone_setting_t predict_tone_setting(logic [FREQ_W-1:0] freq);
    tone_setting_t   s;
    longint unsigned f, pclk, per, act, err, best_err;
    int unsigned     p, best_p;
    s = '0;
    if (freq == 0) begin
      s.silent = 1'b1;
      return s;
    end
    f = freq;
    best_p = 0;
    if (!period_fits(cfg_clock_hz / f)) begin
      best_err = 64'hFFFF_FFFF;
      for (p = 0; p < SEARCH_STEPS; p++) begin
        pclk = cfg_clock_hz / (p + 1);
        per = pclk / f;
        if (period_fits(per)) begin
          act = pclk / per;
          err = (act > f) ? act - f : f - act;
          if (err < best_err) begin
            best_err = err;
            best_p = p;
          end
          // exact hit ends the search
          if (err == 0) break;
        end
      end
    end
    pclk = cfg_clock_hz / (best_p + 1);
    per = pclk / f;
    if (per == 0) begin
      s.silent = 1'b1;
      return s;
    end
    act = pclk / per;
    if (per > PERIOD_MAX) begin
      per = PERIOD_MAX;
      s.clamped = 1'b1;
    end
    s.prescaler   = best_p[PRESC_W-1:0];
    s.period      = per[PERIOD_W-1:0];
    s.match       = MATCH_W'(per / 2);
    s.achieved_hz = act[HZ_W-1:0];
    return s;
  endfunction

  function automatic int unsigned draw_gap(bit idle_on);
    return idle_on ? $urandom_range(GAP_MAX, 0) : 0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_setting(tone_setting_t got);
    tone_setting_t want;
    if (pending_settings.size() == 0) begin
      report_mismatch("result word with nothing expected");
      return;
    end
    want = pending_settings.pop_front();
    if (got.prescaler !== want.prescaler)
      report_mismatch($sformatf("prescaler got %0d want %0d", got.prescaler, want.prescaler));
    if (got.period !== want.period)
      report_mismatch($sformatf("period got %0d want %0d", got.period, want.period));
    if (got.match !== want.match)
      report_mismatch($sformatf("match got %0d want %0d", got.match, want.match));
    if (got.achieved_hz !== want.achieved_hz)
      report_mismatch($sformatf("achieved_hz got %0d want %0d",
                                got.achieved_hz, want.achieved_hz));
    if (got.clamped !== want.clamped)
      report_mismatch($sformatf("clamped got %b want %b", got.clamped, want.clamped));
    if (got.silent !== want.silent)
      report_mismatch($sformatf("silent got %b want %b", got.silent, want.silent));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_settings.push_back(predict_tone_setting(req_if.frequency));
      if (!req_if.valid || req_if.ready) begin
        if (in_gap > 0 || tone_requests.size() == 0) begin
          req_if.valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          req_if.valid <= 1'b1;
          req_if.frequency <= tone_requests.pop_front();
          in_gap <= draw_gap(src_idle_on);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    int unsigned gap_next;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        check_setting({rsp_if.prescaler, rsp_if.period, rsp_if.match,
                       rsp_if.achieved_hz, rsp_if.clamped, rsp_if.silent});
        gap_next = draw_gap(snk_idle_on);
      end else begin
        gap_next = (out_gap > 0) ? out_gap - 1 : 0;
      end
      out_gap <= gap_next;
      rsp_if.ready <= (gap_next == 0) && !hold_off;
    end
  end

  // long receiver stall, so the block backs up into its input
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_CLOCK_HZ:  cfg_clock_hz = data;
      REG_PERIOD_LO: cfg_period_lo = data[PERIOD_W-1:0];
      REG_PERIOD_HI: cfg_period_hi = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tone_requests.size() != 0 || req_if.valid || pending_settings.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // fit_lo..fit_hi is the band where the direct period fits, the rest forces a search
  task automatic queue_tones(int unsigned count, int unsigned fit_lo, int unsigned fit_hi,
                             int unsigned search_pct);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 3)
        tone_requests.push_back('0);
      else if (roll < 3 + search_pct) begin
        if (fit_hi < FREQ_TOP && $urandom_range(1, 0))
          tone_requests.push_back(FREQ_W'($urandom_range(FREQ_TOP, fit_hi + 1)));
        else
          tone_requests.push_back(FREQ_W'($urandom_range(fit_lo - 1, 1)));
      end else
        tone_requests.push_back(FREQ_W'($urandom_range(fit_hi, fit_lo)));
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req_if.valid = 1'b0;
    req_if.frequency = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed tones on the reset settings
    tone_requests.push_back(24'd0);
    tone_requests.push_back(24'd1);
    tone_requests.push_back(24'hFFFFFF);
    tone_requests.push_back(24'hAAAAAA);
    tone_requests.push_back(24'h555555);
    tone_requests.push_back(24'd1000);
    tone_requests.push_back(24'd440);
    tone_requests.push_back(24'd1220);
    tone_requests.push_back(24'd1221);
    tone_requests.push_back(24'd1600000);
    tone_requests.push_back(24'd1600001);
    tone_requests.push_back(24'd3);
    tone_requests.push_back(24'd261);
    wait_drained();

    queue_tones(40, 1221, 1600000, 15);
    wait_drained();

    // receiver holds off while the sender keeps pushing
    src_idle_on = 1'b0;
    hold_request = 1'b1;
    queue_tones(6, 1221, 1600000, 0);
    wait_drained();

    src_idle_on = 1'b1;
    snk_idle_on = 1'b0;
    write_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD_LO, 32'd1);
    write_reg(REG_PERIOD_HI, 32'd65535);
    queue_tones(18, 65537, FREQ_TOP, 15);
    wait_drained();

    // narrow band with a zero lower bound
    src_idle_on = 1'b0;
    snk_idle_on = 1'b1;
    write_reg(REG_CLOCK_HZ, 32'd1000000);
    write_reg(REG_PERIOD_LO, 32'd0);
    write_reg(REG_PERIOD_HI, 32'd200);
    queue_tones(12, 5000, 1000000, 40);
    wait_drained();

    // inverted bounds; the spare index must not disturb anything
    src_idle_on = 1'b1;
    write_reg(REG_CLOCK_HZ, 32'd80000000);
    write_reg(REG_PERIOD_LO, 32'd65535);
    write_reg(REG_PERIOD_HI, 32'd1);
    write_reg(REG_UNUSED, 32'h1234_5678);
    tone_requests.push_back(24'd1000);
    tone_requests.push_back(24'd2000000);
    tone_requests.push_back(24'd12345);
    wait_drained();

    // clock too slow for any period
    write_reg(REG_CLOCK_HZ, 32'd1);
    write_reg(REG_PERIOD_LO, 32'd1);
    write_reg(REG_PERIOD_HI, 32'd65535);
    tone_requests.push_back(24'd5);
    tone_requests.push_back(24'hFFFFFF);
    wait_drained();
    write_reg(REG_CLOCK_HZ, 32'd0);
    tone_requests.push_back(24'd7);
    wait_drained();

    // back to back, no idling on either side
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    write_reg(REG_CLOCK_HZ, 32'd48000000);
    write_reg(REG_PERIOD_LO, 32'd50);
    queue_tones(20, 733, 960000, 15);
    wait_drained();

    repeat (50) @(posedge clk);
    if (pending_settings.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_settings.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ tone_prescaler_period_search_unit.f @@
src/tps_pkg.sv
src/tps_ifs.sv
src/tps_div.sv
src/tone_prescaler_period_search_unit.sv
dv/tone_prescaler_period_search_unit_tb.sv
